// File: hw/rtl/spd_pkg.sv
`default_nettype none
package spd_pkg;

    // Packet layout
    localparam int unsigned PACKET_LENGTH = 16;
    localparam int unsigned NUM_AXES      = 6;
    localparam int unsigned POS_W         = 4;
    localparam int unsigned SUM_W         = 14;
    localparam int unsigned AXIS_W        = 16;

    localparam logic [POS_W-1:0] AXIS_LAST_POS = 4'd12;
    localparam logic [POS_W-1:0] CHECK_HI_POS  = 4'd13;
    localparam logic [POS_W-1:0] CHECK_LO_POS  = 4'd14;
    localparam logic [POS_W-1:0] LAST_POS      = POS_W'(PACKET_LENGTH - 1);

    localparam logic [AXIS_W-1:0] AXIS_OFFSET = 16'd8192;

    // Register reset values
    localparam logic [7:0] HEADER_RESET = 8'd150;
    localparam logic [7:0] TAIL_RESET   = 8'd141;

    // Register indexes
    localparam logic [1:0] CFG_HEADER = 2'd0;
    localparam logic [1:0] CFG_TAIL   = 2'd1;

    // Frame status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TAIL     = 2'd1;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

    typedef logic [AXIS_W-1:0] axis_t;

    typedef struct packed {
        logic [7:0] header_value;
        logic [7:0] tail_value;
    } spd_cfg_t;

    typedef struct packed {
        axis_t [NUM_AXES-1:0] axes;
        logic [1:0]           status;
    } spd_result_t;

endpackage
`default_nettype wire

// File: hw/rtl/spd_frame_engine.sv
`default_nettype none
module spd_frame_engine (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire spd_pkg::spd_cfg_t    cfg,
    input  wire logic                 byte_valid,
    input  wire logic [7:0]           rx_byte,
    output logic                      res_fire,
    output spd_pkg::spd_result_t      res
);
    import spd_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              in_frame_reg, in_frame_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [7:0]        prev_reg, prev_next;
    axis_t             check_reg, check_next;
    axis_t [NUM_AXES-1:0] commit_reg, commit_next;
    axis_t [NUM_AXES-1:0] staged_reg;

    logic              stage_we;
    logic [2:0]        stage_idx;
    axis_t             pair_value;
    logic [1:0]        status;

    // byte pair to axis value, modulo 2^16
    assign pair_value = {1'b0, prev_reg, 7'b0} + {8'b0, rx_byte} - AXIS_OFFSET;
    assign stage_idx  = pos_reg[3:1] - 3'd1;

    // frame checks, tail takes precedence
    always_comb begin
        if (rx_byte != cfg.tail_value) begin
            status = STATUS_TAIL;
        end else if ({2'b0, sum_reg} != check_reg) begin
            status = STATUS_CHECKSUM;
        end else begin
            status = STATUS_OK;
        end
    end

    // per-byte state update
    always_comb begin
        pos_next      = pos_reg;
        in_frame_next = in_frame_reg;
        sum_next      = sum_reg;
        prev_next     = prev_reg;
        check_next    = check_reg;
        commit_next   = commit_reg;
        stage_we      = 1'b0;
        res_fire      = 1'b0;
        if (byte_valid) begin
            if (!in_frame_reg) begin
                if (rx_byte == cfg.header_value) begin
                    in_frame_next = 1'b1;
                    sum_next      = {6'b0, rx_byte};
                    pos_next      = 4'd1;
                end
            end else begin
                if (pos_reg <= AXIS_LAST_POS) begin
                    sum_next = sum_reg + {6'b0, rx_byte};
                    if (pos_reg[0]) begin
                        prev_next = rx_byte;
                    end else begin
                        stage_we = 1'b1;
                    end
                end else if (pos_reg == CHECK_HI_POS) begin
                    prev_next = rx_byte;
                end else if (pos_reg == CHECK_LO_POS) begin
                    check_next = {1'b0, prev_reg, 7'b0} + {8'b0, rx_byte};
                end

                if (pos_reg != LAST_POS) begin
                    pos_next = pos_reg + 4'd1;
                end else begin
                    res_fire      = 1'b1;
                    in_frame_next = 1'b0;
                    pos_next      = '0;
                    if (status == STATUS_OK) begin
                        commit_next = staged_reg;
                    end
                end
            end
        end
    end

    assign res.axes   = commit_next;
    assign res.status = status;

    // control and committed state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            in_frame_reg <= 1'b0;
            sum_reg      <= '0;
            prev_reg     <= '0;
            check_reg    <= '0;
            commit_reg   <= '0;
        end else begin
            pos_reg      <= pos_next;
            in_frame_reg <= in_frame_next;
            sum_reg      <= sum_next;
            prev_reg     <= prev_next;
            check_reg    <= check_next;
            commit_reg   <= commit_next;
        end
    end

    // staged axes, written before read in every packet
    always_ff @(posedge aclk) begin
        if (stage_we) begin
            staged_reg[stage_idx] <= pair_value;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/six_axis_packet_deframer_core.sv
// Flow: an accepted byte waits in the input register until the result slot
//   can take a transaction; a result it completes goes to the result register.
// Throughput: one byte per cycle while the result slot is empty or being taken;
//   the frame update sits between the input register and the result register.
// Reset: synchronous, active low; hunts for a header, committed axes zero,
//   registers at header 150 and tail 141.
`default_nettype none
module six_axis_packet_deframer_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_axis_x,
    output logic [15:0]      m_axis_y,
    output logic [15:0]      m_axis_z,
    output logic [15:0]      m_axis_a,
    output logic [15:0]      m_axis_b,
    output logic [15:0]      m_axis_c,
    output logic [1:0]       m_frame_status
);
    import spd_pkg::*;

    spd_cfg_t    cfg_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg, out_valid_next;
    spd_result_t out_reg;

    logic        advance;
    logic        proc;
    logic        res_fire;
    spd_result_t res;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_value <= HEADER_RESET;
            cfg_reg.tail_value   <= TAIL_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_HEADER: cfg_reg.header_value <= cfg_wdata;
                CFG_TAIL:   cfg_reg.tail_value   <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // input stage advances whenever the result slot can take a transaction
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign proc    = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    spd_frame_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .byte_valid (proc),
        .rx_byte    (in_byte_reg),
        .res_fire   (res_fire),
        .res        (res)
    );

    // result register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (proc && res_fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && res_fire) begin
            out_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_axis_x       = out_reg.axes[0];
    assign m_axis_y       = out_reg.axes[1];
    assign m_axis_z       = out_reg.axes[2];
    assign m_axis_a       = out_reg.axes[3];
    assign m_axis_b       = out_reg.axes[4];
    assign m_axis_c       = out_reg.axes[5];
    assign m_frame_status = out_reg.status;

endmodule
`default_nettype wire

// File: hw/rtl/spd_port_checker.sv
`default_nettype none
module spd_port_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [15:0] m_axis_x,
    input  wire logic [15:0] m_axis_c,
    input  wire logic [1:0]  m_frame_status
);
    import spd_pkg::*;

    // a held result keeps its payload until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_axis_x) && $stable(m_axis_c)
            && $stable(m_frame_status))
        else $error("result changed while stalled");

    // reset empties the result slot
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // only the three defined status codes appear
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_status == STATUS_OK || m_frame_status == STATUS_TAIL
            || m_frame_status == STATUS_CHECKSUM))
        else $error("bad frame status");

    // a new result follows an input transaction through the input and result registers
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without a causing byte");

endmodule

bind six_axis_packet_deframer_core spd_port_checker u_port_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_axis_x       (m_axis_x),
    .m_axis_c       (m_axis_c),
    .m_frame_status (m_frame_status)
);
`default_nettype wire

// File: tb/sv/spd_frame_checker.sv
`default_nettype none
module spd_frame_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [15:0] m_axis_x,
    input  wire logic [15:0] m_axis_y,
    input  wire logic [15:0] m_axis_z,
    input  wire logic [15:0] m_axis_a,
    input  wire logic [15:0] m_axis_b,
    input  wire logic [15:0] m_axis_c,
    input  wire logic [1:0]  m_frame_status,
    output int               mismatch_count,
    output int               frames_pending
);
    import spd_pkg::*;

    // Shadow registers
    logic [7:0]       hdr_byte;
    logic [7:0]       tail_byte;

    // Shadow deframer state
    logic [POS_W-1:0] pkt_pos;
    logic             in_pkt;
    logic [SUM_W-1:0] byte_sum;
    logic [7:0]       pair_first;
    logic [15:0]      check_word;
    axis_t            staged [NUM_AXES];
    axis_t            committed [NUM_AXES];

    // Frames predicted but not yet seen on the result channel
    spd_result_t      frames_due [$];

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: MISMATCH %s: got 0x%04h, expected 0x%04h", $time, what, got, want);
        mismatch_count++;
    endtask

    // One received byte through the frame state machine
    task automatic deframe_byte(input logic [7:0] b);
        spd_result_t frame;
        logic [1:0]  st;
        int          idx;
        int          k;
        if (!in_pkt) begin
            // hunting: only the header byte opens a packet
            if (b == hdr_byte) begin
                in_pkt   = 1'b1;
                byte_sum = SUM_W'(b);
                pkt_pos  = 4'd1;
            end
        end else begin
            if (pkt_pos <= AXIS_LAST_POS) begin
                byte_sum = byte_sum + SUM_W'(b);
                if (pkt_pos[0]) begin
                    pair_first = b;
                end else begin
                    idx = int'(pkt_pos >> 1) - 1;
                    staged[idx] = axis_t'({1'b0, pair_first, 7'd0}) + axis_t'(b)
                                  - AXIS_OFFSET;
                end
            end else if (pkt_pos == CHECK_HI_POS) begin
                pair_first = b;
            end else if (pkt_pos == CHECK_LO_POS) begin
                check_word = {1'b0, pair_first, 7'd0} + {8'd0, b};
            end

            if (pkt_pos != LAST_POS) begin
                pkt_pos = pkt_pos + 4'd1;
            end else begin
                // tail check wins over checksum check
                if (b != tail_byte)
                    st = STATUS_TAIL;
                else if ({2'b00, byte_sum} != check_word)
                    st = STATUS_CHECKSUM;
                else
                    st = STATUS_OK;
                if (st == STATUS_OK) begin
                    for (k = 0; k < NUM_AXES; k++)
                        committed[k] = staged[k];
                end
                for (k = 0; k < NUM_AXES; k++)
                    frame.axes[k] = committed[k];
                frame.status = st;
                frames_due.push_back(frame);
                in_pkt  = 1'b0;
                pkt_pos = '0;
            end
        end
    endtask

    // One result transaction against the oldest predicted frame
    task automatic check_frame();
        spd_result_t want;
        axis_t       got [NUM_AXES];
        int          k;
        got[0] = m_axis_x;
        got[1] = m_axis_y;
        got[2] = m_axis_z;
        got[3] = m_axis_a;
        got[4] = m_axis_b;
        got[5] = m_axis_c;
        if (frames_due.size() == 0) begin
            report_mismatch("result with no frame pending, frame_status",
                            {14'd0, m_frame_status}, 16'd0);
        end else begin
            want = frames_due.pop_front();
            for (k = 0; k < NUM_AXES; k++) begin
                if (got[k] !== want.axes[k])
                    report_mismatch($sformatf("axis %0d", k), got[k], want.axes[k]);
            end
            if (m_frame_status !== want.status)
                report_mismatch("frame_status", {14'd0, m_frame_status},
                                {14'd0, want.status});
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            hdr_byte   = HEADER_RESET;
            tail_byte  = TAIL_RESET;
            pkt_pos    = '0;
            in_pkt     = 1'b0;
            byte_sum   = '0;
            pair_first = '0;
            check_word = '0;
            for (int k = 0; k < NUM_AXES; k++) begin
                staged[k]    = '0;
                committed[k] = '0;
            end
            frames_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_HEADER: hdr_byte  = cfg_wdata;
                    CFG_TAIL:   tail_byte = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready)
                check_frame();
            if (s_valid && s_ready)
                deframe_byte(s_rx_byte);
        end
        frames_pending = frames_due.size();
    end

endmodule
`default_nettype wire

// File: tb/sv/six_axis_packet_deframer_core_tb.sv
`default_nettype none
module six_axis_packet_deframer_core_tb;
    import spd_pkg::*;

    localparam int QUIET_LIMIT    = 1000;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 6;
    localparam int NUM_PHASES     = 6;
    localparam int PKTS_PER_PHASE = 6;

    // index values with no register behind them
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

    typedef enum int {
        PKT_GOOD,
        PKT_EXTREMES,
        PKT_HDR_INSIDE,
        PKT_BAD_TAIL,
        PKT_BAD_SUM,
        PKT_BAD_BOTH,
        PKT_BIG_CHECK,
        PKT_TRUNCATED
    } pkt_kind_e;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_axis_x;
    logic [15:0] m_axis_y;
    logic [15:0] m_axis_z;
    logic [15:0] m_axis_a;
    logic [15:0] m_axis_b;
    logic [15:0] m_axis_c;
    logic [1:0]  m_frame_status;

    int          mismatch_count;
    int          frames_pending;
    int          quiet_cycles;

    // stimulus-side copies of the registers, used to build packets
    logic [7:0]  cur_header;
    logic [7:0]  cur_tail;
    bit          src_idle_on;
    bit          sink_idle_on;
    bit          hold_req;

    always #5 aclk = ~aclk;

    six_axis_packet_deframer_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_axis_x       (m_axis_x),
        .m_axis_y       (m_axis_y),
        .m_axis_z       (m_axis_z),
        .m_axis_a       (m_axis_a),
        .m_axis_b       (m_axis_b),
        .m_axis_c       (m_axis_c),
        .m_frame_status (m_frame_status)
    );

    spd_frame_checker u_frame_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_axis_x       (m_axis_x),
        .m_axis_y       (m_axis_y),
        .m_axis_z       (m_axis_z),
        .m_axis_a       (m_axis_a),
        .m_axis_b       (m_axis_b),
        .m_axis_c       (m_axis_c),
        .m_frame_status (m_frame_status),
        .mismatch_count (mismatch_count),
        .frames_pending (frames_pending)
    );

    // One byte transaction; called and returns at a rising edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Bytes between packets; header value kept out so framing holds
    task automatic send_noise(input int count);
        logic [7:0] b;
        int         k;
        for (k = 0; k < count; k++) begin
            b = 8'($urandom_range(0, 255));
            while (b == cur_header) b = 8'($urandom_range(0, 255));
            send_byte(b);
        end
    endtask

    function automatic logic [7:0] data_byte();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 8'h00;
        else if (pick == 1)
            return 8'hff;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic pkt_kind_e pick_kind();
        case ($urandom_range(0, 15))
            8:       return PKT_HDR_INSIDE;
            9:       return PKT_BAD_TAIL;
            10:      return PKT_BAD_SUM;
            11:      return PKT_BAD_BOTH;
            12:      return PKT_BIG_CHECK;
            13:      return PKT_TRUNCATED;
            14:      return PKT_EXTREMES;
            default: return PKT_GOOD;
        endcase
    endfunction

    // Build a packet with a valid check word, then corrupt it per kind
    task automatic send_packet(input pkt_kind_e kind);
        logic [7:0]       pkt [PACKET_LENGTH];
        logic [SUM_W-1:0] sum;
        int               k;
        int               cut;
        pkt[0] = cur_header;
        for (k = 1; k <= 12; k++)
            pkt[k] = data_byte();
        if (kind == PKT_EXTREMES) begin
            // -8192, 24703, 0, -1, 8192, and a header-valued pair
            pkt[1]  = 8'd0;   pkt[2]  = 8'd0;
            pkt[3]  = 8'd255; pkt[4]  = 8'd255;
            pkt[5]  = 8'd64;  pkt[6]  = 8'd0;
            pkt[7]  = 8'd63;  pkt[8]  = 8'd127;
            pkt[9]  = 8'd128; pkt[10] = 8'd0;
            pkt[11] = cur_header;
            pkt[12] = cur_header;
        end
        if (kind == PKT_HDR_INSIDE)
            pkt[$urandom_range(1, 12)] = cur_header;
        sum = '0;
        for (k = 0; k <= 12; k++)
            sum = sum + SUM_W'(pkt[k]);
        pkt[13] = {1'b0, sum[13:7]};
        pkt[14] = {1'b0, sum[6:0]};
        pkt[15] = cur_tail;
        case (kind)
            PKT_BAD_TAIL: pkt[15] = cur_tail ^ 8'($urandom_range(1, 255));
            PKT_BAD_SUM: begin
                if ($urandom_range(0, 1) == 0)
                    pkt[14] = pkt[14] ^ 8'($urandom_range(1, 127));
                else
                    pkt[13] = 8'($urandom_range(0, 255));
            end
            PKT_BAD_BOTH: begin
                pkt[14] = pkt[14] ^ 8'($urandom_range(1, 127));
                pkt[15] = cur_tail ^ 8'($urandom_range(1, 255));
            end
            PKT_BIG_CHECK: begin
                pkt[13] = 8'($urandom_range(128, 255));
                pkt[14] = 8'($urandom_range(0, 255));
            end
            default: ;
        endcase
        // a cut packet swallows the head of the next one
        cut = (kind == PKT_TRUNCATED) ? int'($urandom_range(2, 12)) : int'(PACKET_LENGTH);
        for (k = 0; k < cut; k++)
            send_byte(pkt[k]);
    endtask

    // Stop sending and wait out every pending frame plus pipeline bytes
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (frames_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write both registers and one unused index; block must be idle
    task automatic program_regs(input logic [7:0] hdr, input logic [7:0] tail);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_HEADER;
        cfg_wdata <= hdr;
        @(posedge aclk);
        cfg_index <= CFG_TAIL;
        cfg_wdata <= tail;
        @(posedge aclk);
        cfg_index <= ($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI;
        cfg_wdata <= 8'($urandom_range(0, 255));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        cur_header = hdr;
        cur_tail   = tail;
    endtask

    // Result side: random ready bursts and one long hold-off
    initial begin
        bit held;
        held = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("six_axis_packet_deframer_core_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        int         phase;
        int         k;
        logic [7:0] v;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_HEADER;
        cfg_wdata <= 8'd0;
        s_valid   <= 1'b0;
        s_rx_byte <= 8'd0;
        cur_header   = HEADER_RESET;
        cur_tail     = TAIL_RESET;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        hold_req     = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: hunting bytes at the extremes, then an extreme-value packet
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(HEADER_RESET - 8'd1);
        send_packet(PKT_EXTREMES);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase != 0) begin
                settle();
                case (phase)
                    1: program_regs(8'h00, 8'hff);
                    2: program_regs(8'hff, 8'h00);
                    3: program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    4: begin
                        v = 8'($urandom_range(0, 255));
                        program_regs(v, v);
                    end
                    default: program_regs(HEADER_RESET, TAIL_RESET);
                endcase
            end
            // phase 3 streams into a stalled result side; last phase runs flat out
            src_idle_on  = (phase != 3) && (phase != NUM_PHASES - 1);
            sink_idle_on = (phase != NUM_PHASES - 1);
            if (phase == 3)
                hold_req = 1'b1;
            for (k = 0; k < PKTS_PER_PHASE; k++) begin
                if (phase != 3)
                    send_noise($urandom_range(0, 2));
                send_packet(pick_kind());
            end
        end

        settle();
        if (mismatch_count == 0 && frames_pending == 0) begin
            $display("six_axis_packet_deframer_core_tb: done, clean");
        end else begin
            $display("six_axis_packet_deframer_core_tb: done, errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
